>>> src/accumulator_cpu_execute_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the accumulator CPU execute block.
// Concurrent checks that are clocked on i_clk and, where asked, quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_EXECUTE_MACROS_SVH
`define ACCUMULATOR_CPU_EXECUTE_MACROS_SVH

`ifndef ASSERT_OFF
`define ACE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define ACE_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ACE_ASSERT(lbl, prop, msg)
`define ACE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/ace_pkg.sv
// ---------------------------------------------------------------------------
// ace_pkg
// Types and constants shared by the accumulator CPU execute block.
// ---------------------------------------------------------------------------
package ace_pkg;

    localparam int DATA_WORDS = 256;
    localparam int DATA_AW    = $clog2(DATA_WORDS);
    localparam int PC_W       = 8;
    localparam int WORD_W     = 32;
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 80;

    localparam logic [3:0] FUNC_DEC = 4'd0;
    localparam logic [3:0] FUNC_LDA = 4'd1;
    localparam logic [3:0] FUNC_LDB = 4'd2;
    localparam logic [3:0] FUNC_LDI = 4'd3;
    localparam logic [3:0] FUNC_STR = 4'd4;
    localparam logic [3:0] FUNC_XCH = 4'd5;
    localparam logic [3:0] FUNC_JMP = 4'd6;
    localparam logic [3:0] FUNC_JZS = 4'd7;
    localparam logic [3:0] FUNC_JVS = 4'd8;
    localparam logic [3:0] FUNC_ADD = 4'd9;
    localparam logic [3:0] FUNC_HLT = 4'd10;

    typedef struct packed {
        logic [3:0]               func;
        logic [DATA_AW-1:0]       data_address;
        logic signed [WORD_W-1:0] immediate_value;
        logic [PC_W-1:0]          jump_target;
    } t_instr;

    typedef struct packed {
        logic [PC_W-1:0]          program_counter;
        logic signed [WORD_W-1:0] accumulator_a;
        logic signed [WORD_W-1:0] register_b_value;
        logic                     zero_flag;
        logic                     overflow_flag;
        logic                     halted;
    } t_result;

    typedef struct packed {
        logic               en;
        logic [DATA_AW-1:0] addr;
        logic [WORD_W-1:0]  data;
    } t_mem_wr;

endpackage

>>> src/ace_dmem.sv
// ---------------------------------------------------------------------------
// ace_dmem
// Data memory: one write port, one registered read port with write bypass.
// ---------------------------------------------------------------------------
module ace_dmem
    import ace_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rd_en,
    input  logic [DATA_AW-1:0] i_rd_addr,
    input  t_mem_wr            i_wr,
    output logic [WORD_W-1:0]  o_rd_data
);

    logic [WORD_W-1:0] r_mem [DATA_WORDS];
    logic [WORD_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // A write in the same cycle to the word being read is passed straight on.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/ace_core.sv
// ---------------------------------------------------------------------------
// ace_core
// Architectural registers and the execute logic for one instruction a cycle while i_fire is high.
// ---------------------------------------------------------------------------
module ace_core
    import ace_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  t_instr            i_instr,
    input  logic [WORD_W-1:0] i_rd_data,
    output t_result           o_result,
    output t_mem_wr           o_wr
);

    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [PC_W-1:0]   r_pc;
    logic              r_zero;
    logic              r_ovf;

    logic [WORD_W-1:0] n_a;
    logic [WORD_W-1:0] n_b;
    logic [PC_W-1:0]   n_pc;
    logic              n_zero;
    logic              n_ovf;
    logic              n_halted;
    logic [PC_W-1:0]   pc_inc;
    logic [WORD_W-1:0] sum;
    logic              add_ovf;

    assign pc_inc  = r_pc + PC_W'(1);
    assign sum     = r_a + r_b;
    assign add_ovf = (r_a[WORD_W-1] == r_b[WORD_W-1]) && (sum[WORD_W-1] != r_a[WORD_W-1]);

    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_pc     = pc_inc;
        n_zero   = r_zero;
        n_ovf    = r_ovf;
        n_halted = 1'b0;
        o_wr.en   = 1'b0;
        o_wr.addr = i_instr.data_address;
        o_wr.data = r_a;
        unique case (i_instr.func)
            FUNC_DEC: begin
                o_wr.en   = i_fire;
                o_wr.data = '0;
            end
            FUNC_LDA: n_a = i_rd_data;
            FUNC_LDB: n_b = i_rd_data;
            FUNC_LDI: n_a = i_instr.immediate_value;
            FUNC_STR: o_wr.en = i_fire;
            FUNC_XCH: begin
                n_a = r_b;
                n_b = r_a;
            end
            FUNC_JMP: n_pc = i_instr.jump_target;
            FUNC_JZS: if (r_zero) begin
                n_pc = i_instr.jump_target;
            end
            FUNC_JVS: if (r_ovf) begin
                n_pc = i_instr.jump_target;
            end
            FUNC_ADD: begin
                if (add_ovf) begin
                    n_ovf = 1'b1;
                end else begin
                    n_a    = sum;
                    n_zero = (sum == '0);
                end
            end
            FUNC_HLT: begin
                n_a      = '0;
                n_b      = '0;
                n_zero   = 1'b0;
                n_ovf    = 1'b0;
                n_halted = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a    <= '0;
            r_b    <= '0;
            r_pc   <= '0;
            r_zero <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (i_fire) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_pc   <= n_pc;
            r_zero <= n_zero;
            r_ovf  <= n_ovf;
        end
    end

    assign o_result.program_counter  = n_pc;
    assign o_result.accumulator_a    = n_a;
    assign o_result.register_b_value = n_b;
    assign o_result.zero_flag        = n_zero;
    assign o_result.overflow_flag    = n_ovf;
    assign o_result.halted           = n_halted;

endmodule

>>> src/accumulator_cpu_execute.sv
// ---------------------------------------------------------------------------
// accumulator_cpu_execute
// Execute stage of a two-register accumulator machine with a data memory.
// ---------------------------------------------------------------------------
//  Channel   Direction  Beat contents
//  s_axis    in         one decoded instruction
//  m_axis    out        machine state after that instruction
//
//  An instruction is taken into the execute register, its memory word is read on
//  that same edge, and it executes when the output register can take its result.
//  One instruction a cycle is sustained while m_axis is not stalled.
//  A stalled output holds the executing instruction, and input stalls with it.
//  Reset clears the registers, flags and pipeline; memory contents are kept.
// ---------------------------------------------------------------------------
`include "accumulator_cpu_execute_macros.svh"

module accumulator_cpu_execute
    import ace_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // func[3:0], data_address[11:4], immediate_value[43:12], jump_target[51:44]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // program_counter[7:0], accumulator_a[39:8], register_b_value[71:40],
    // zero_flag[72], overflow_flag[73], halted[74]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic              r_ex_valid;
    t_instr            r_ex_instr;
    logic              r_out_valid;
    t_result           r_out;
    logic              in_fire;
    logic              ex_fire;
    t_instr            in_instr;
    t_result           ex_result;
    t_mem_wr           mem_wr;
    logic [WORD_W-1:0] rd_data;

    assign in_instr.func            = s_axis_tdata[3:0];
    assign in_instr.data_address    = s_axis_tdata[11:4];
    assign in_instr.immediate_value = s_axis_tdata[43:12];
    assign in_instr.jump_target     = s_axis_tdata[51:44];

    assign ex_fire       = r_ex_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_ex_valid || ex_fire;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    ace_dmem u_dmem (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (in_instr.data_address),
        .i_wr      (mem_wr),
        .o_rd_data (rd_data)
    );

    ace_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (ex_fire),
        .i_instr   (r_ex_instr),
        .i_rd_data (rd_data),
        .o_result  (ex_result),
        .o_wr      (mem_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_ex_valid <= 1'b1;
            end else if (ex_fire) begin
                r_ex_valid <= 1'b0;
            end
            if (ex_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ex_instr <= in_instr;
        end
        if (ex_fire) begin
            r_out <= ex_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.halted, r_out.overflow_flag, r_out.zero_flag,
                            r_out.register_b_value, r_out.accumulator_a,
                            r_out.program_counter};

    `ACE_ASSERT(a_ex_fills_out, ex_fire |=> r_out_valid, "executed beat did not reach output")
    `ACE_ASSERT(a_ready_when_empty, !r_out_valid |-> s_axis_tready, "input blocked with output free")
    `ACE_ASSERT(a_wr_only_on_exec, mem_wr.en |-> ex_fire, "memory written without execution")
    `ACE_ASSERT(a_halt_clears, (r_out_valid && r_out.halted) |-> (r_out.accumulator_a == '0 && r_out.register_b_value == '0 && !r_out.zero_flag && !r_out.overflow_flag), "halt left state set")
    `ACE_ASSERT_ALWAYS(a_reset_empty, !$past(i_rst_n) |-> (r_ex_valid !== 1'b1 && r_out_valid !== 1'b1), "pipeline not empty after reset")

endmodule

>>> test/accumulator_cpu_execute_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// accumulator_cpu_execute_tb
// Runs short instruction sequences through the execute stage and checks the
// machine state that comes back for every instruction. A directed program
// covers the extremes first. Random programs follow under four source and
// sink idling patterns. The expected state comes from a behavioural model of
// the machine that is kept inside the bench.
// ---------------------------------------------------------------------------
module accumulator_cpu_execute_tb;
    import ace_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam logic signed [WORD_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic [3:0] FUNC_UNUSED_FIRST = 4'd11;
    localparam logic [3:0] FUNC_UNUSED_LAST  = 4'd15;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // func, data_address, immediate_value, jump_target (lowest bits first)
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // program_counter, accumulator_a, register_b_value, zero_flag,
    // overflow_flag, halted (lowest bits first)
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic signed [WORD_W-1:0] acc_a;
    logic signed [WORD_W-1:0] acc_b;
    logic [PC_W-1:0]          prog_counter;
    logic                     flag_zero;
    logic                     flag_ovf;
    logic [WORD_W-1:0]        data_mem [DATA_WORDS];
    bit                       word_valid [DATA_WORDS];
    logic [DATA_AW-1:0]       written_addrs [$];

    t_result     expected_states [$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    accumulator_cpu_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= stall_pct);
    end

    function automatic void mark_written(logic [DATA_AW-1:0] addr);
        if (!word_valid[addr]) begin
            word_valid[addr] = 1'b1;
            written_addrs.push_back(addr);
        end
    endfunction

    function automatic t_result next_machine_state(t_instr ins);
        t_result         r;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] swap;
        logic [PC_W-1:0] pc_step;
        pc_step = prog_counter + PC_W'(1);
        r.halted = 1'b0;
        prog_counter = pc_step;
        case (ins.func)
            FUNC_DEC: begin
                data_mem[ins.data_address] = '0;
                mark_written(ins.data_address);
            end
            FUNC_LDA: acc_a = data_mem[ins.data_address];
            FUNC_LDB: acc_b = data_mem[ins.data_address];
            FUNC_LDI: acc_a = ins.immediate_value;
            FUNC_STR: begin
                data_mem[ins.data_address] = acc_a;
                mark_written(ins.data_address);
            end
            FUNC_XCH: begin
                swap = acc_a;
                acc_a = acc_b;
                acc_b = swap;
            end
            FUNC_JMP: prog_counter = ins.jump_target;
            FUNC_JZS: if (flag_zero) prog_counter = ins.jump_target;
            FUNC_JVS: if (flag_ovf) prog_counter = ins.jump_target;
            FUNC_ADD: begin
                sum = acc_a + acc_b;
                if (acc_a[WORD_W-1] == acc_b[WORD_W-1] && sum[WORD_W-1] != acc_a[WORD_W-1]) begin
                    flag_ovf = 1'b1;
                end else begin
                    acc_a = sum;
                    flag_zero = (sum == '0);
                end
            end
            FUNC_HLT: begin
                acc_a = '0;
                acc_b = '0;
                flag_zero = 1'b0;
                flag_ovf = 1'b0;
                r.halted = 1'b1;
            end
            default: ;
        endcase
        r.program_counter = prog_counter;
        r.accumulator_a = acc_a;
        r.register_b_value = acc_b;
        r.zero_flag = flag_zero;
        r.overflow_flag = flag_ovf;
        return r;
    endfunction

    function automatic void compare_field(string name, logic [WORD_W-1:0] want,
                                          logic [WORD_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.program_counter = m_axis_tdata[7:0];
            got.accumulator_a = m_axis_tdata[39:8];
            got.register_b_value = m_axis_tdata[71:40];
            got.zero_flag = m_axis_tdata[72];
            got.overflow_flag = m_axis_tdata[73];
            got.halted = m_axis_tdata[74];
            if (expected_states.size() == 0) begin
                $error("Result beat arrived with no instruction outstanding.");
                error_count++;
            end else begin
                want = expected_states.pop_front();
                compare_field("program_counter", WORD_W'(want.program_counter),
                              WORD_W'(got.program_counter));
                compare_field("accumulator_a", want.accumulator_a, got.accumulator_a);
                compare_field("register_b_value", want.register_b_value,
                              got.register_b_value);
                compare_field("zero_flag", WORD_W'(want.zero_flag), WORD_W'(got.zero_flag));
                compare_field("overflow_flag", WORD_W'(want.overflow_flag),
                              WORD_W'(got.overflow_flag));
                compare_field("halted", WORD_W'(want.halted), WORD_W'(got.halted));
            end
        end
    end

    task automatic send_instr(t_instr ins);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, ins.jump_target, ins.immediate_value, ins.data_address,
                         ins.func};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_states.push_back(next_machine_state(ins));
        if ($urandom_range(99, 0) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < idle_pct);
        end
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (expected_states.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_instr instr_of(logic [3:0] func, logic [DATA_AW-1:0] addr,
                                        logic signed [WORD_W-1:0] imm,
                                        logic [PC_W-1:0] target);
        t_instr ins;
        ins.func = func;
        ins.data_address = addr;
        ins.immediate_value = imm;
        ins.jump_target = target;
        return ins;
    endfunction

    function automatic t_instr random_instr();
        t_instr      ins;
        int unsigned pick;
        pick = $urandom_range(99, 0);
        ins.data_address = ($urandom_range(99, 0) < 70) ? DATA_AW'($urandom_range(15, 0))
                                                         : DATA_AW'($urandom_range(255, 0));
        ins.jump_target = PC_W'($urandom_range(255, 0));
        case ($urandom_range(6, 0))
            0: ins.immediate_value = '0;
            1: ins.immediate_value = INT_MAX;
            2: ins.immediate_value = INT_MIN;
            3: ins.immediate_value = $urandom();
            default: ins.immediate_value = $signed($urandom_range(16, 0)) - 8;
        endcase
        if (pick < 5)        ins.func = FUNC_DEC;
        else if (pick < 15)  ins.func = FUNC_LDA;
        else if (pick < 27)  ins.func = FUNC_LDB;
        else if (pick < 41)  ins.func = FUNC_LDI;
        else if (pick < 51)  ins.func = FUNC_STR;
        else if (pick < 59)  ins.func = FUNC_XCH;
        else if (pick < 64)  ins.func = FUNC_JMP;
        else if (pick < 70)  ins.func = FUNC_JZS;
        else if (pick < 76)  ins.func = FUNC_JVS;
        else if (pick < 94)  ins.func = FUNC_ADD;
        else if (pick < 97)  ins.func = FUNC_HLT;
        else ins.func = 4'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
        if (ins.func == FUNC_LDA || ins.func == FUNC_LDB) begin
            if (written_addrs.size() == 0) begin
                ins.func = FUNC_STR;
            end else begin
                ins.data_address = written_addrs[$urandom_range(written_addrs.size() - 1, 0)];
            end
        end
        return ins;
    endfunction

    task automatic run_random_program(int unsigned count, int unsigned send_pct,
                                      int unsigned sink_pct);
        idle_pct = send_pct;
        stall_pct = sink_pct;
        repeat (count) send_instr(random_instr());
        wait_for_results();
    endtask

    task automatic test_directed();
        idle_pct = 0;
        stall_pct = 0;
        send_instr(instr_of(FUNC_DEC, 8'd0, INT_MIN, 8'd255));
        send_instr(instr_of(FUNC_DEC, 8'd255, INT_MAX, 8'd0));
        send_instr(instr_of(FUNC_LDA, 8'd0, -32'sd1, 8'd17));
        send_instr(instr_of(FUNC_LDI, 8'd255, INT_MAX, 8'd255));
        send_instr(instr_of(FUNC_STR, 8'd255, '0, 8'd0));
        send_instr(instr_of(FUNC_LDI, 8'd0, INT_MIN, 8'd0));
        send_instr(instr_of(FUNC_STR, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_LDB, 8'd255, '0, 8'd0));
        send_instr(instr_of(FUNC_ADD, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_JZS, 8'd0, '0, 8'd200));
        send_instr(instr_of(FUNC_XCH, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_LDB, 8'd255, '0, 8'd0));
        send_instr(instr_of(FUNC_ADD, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_JVS, 8'd0, '0, 8'd255));
        send_instr(instr_of(FUNC_ADD, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_LDI, 8'd0, -32'sd1, 8'd0));
        send_instr(instr_of(FUNC_STR, 8'd7, '0, 8'd0));
        send_instr(instr_of(FUNC_LDB, 8'd7, '0, 8'd0));
        send_instr(instr_of(FUNC_LDI, 8'd0, 32'sd1, 8'd0));
        send_instr(instr_of(FUNC_ADD, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_JZS, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_JMP, 8'd0, '0, 8'd255));
        send_instr(instr_of(FUNC_JVS, 8'd0, '0, 8'd128));
        send_instr(instr_of(FUNC_HLT, 8'd0, '0, 8'd0));
        send_instr(instr_of(FUNC_JVS, 8'd0, '0, 8'd64));
        send_instr(instr_of(FUNC_UNUSED_FIRST, 8'd255, INT_MIN, 8'd255));
        send_instr(instr_of(FUNC_UNUSED_LAST, 8'd255, INT_MAX, 8'd255));
        wait_for_results();
    endtask

    task automatic test_full_rate();
        run_random_program(360, 0, 0);
    endtask

    task automatic test_sparse_source();
        run_random_program(360, 58, 0);
    endtask

    task automatic test_slow_sink();
        run_random_program(360, 0, 58);
    endtask

    task automatic test_mixed_idle();
        run_random_program(360, 33, 33);
    endtask

    initial begin
        acc_a = '0;
        acc_b = '0;
        prog_counter = '0;
        flag_zero = 1'b0;
        flag_ovf = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_full_rate();
        test_sparse_source();
        test_slow_sink();
        test_mixed_idle();
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
